@@ sv/sst_pkg.sv @@
// Package for the summary statistics block: field widths, the count limit,
// the sample extremes and the request/response structs of the math unit.
// No dependencies.
package sst_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int SUM_W    = 32;
  localparam int SQ_W     = 47;
  localparam int RES_W    = 24;

  // Largest number of samples a set can hold.
  localparam logic [COUNT_W-1:0] MAX_COUNT = 16'hFFFF;

  // Extremes of a sample, used as the reset values of the running min and max.
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Start of a final computation, with the totals of the set.
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]    sum_squares;
  } sst_req_t;

  // End of a final computation, with the mean and standard deviation.
  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] mean_q8;
    logic [RES_W-1:0] std_q8;
  } sst_rsp_t;

endpackage

@@ sv/sst_math.sv @@
// Sequenced math unit of the summary statistics block: mean and standard
// deviation from count, sum and sum of squares over one shared 64-bit adder.
// Depends on sst_pkg.
module sst_math (
  input  logic              clk,
  input  logic              rst,
  input  sst_pkg::sst_req_t req,
  output sst_pkg::sst_rsp_t rsp
);
  import sst_pkg::*;

  typedef enum logic [2:0] {
    IDLE, MUL_ADD, MUL_SUB, ROOT, DIV_STD, DIV_MEAN
  } state_t;

  localparam logic [5:0] MUL_ADD_STEPS = 6'd16;
  localparam logic [5:0] MUL_SUB_STEPS = 6'd32;
  localparam logic [5:0] ROOT_STEPS    = 6'd40;
  localparam logic [5:0] DIV_STEPS     = 6'd40;

  state_t             state;
  logic [5:0]         cnt;
  logic [63:0]        acc;
  logic [63:0]        mcand;
  logic [31:0]        mplier;
  logic [42:0]        rem;
  logic [39:0]        q;
  logic [COUNT_W-1:0] count;
  logic [31:0]        abs_sum;
  logic               neg;
  logic [RES_W-1:0]   mean;
  logic [RES_W-1:0]   stdv;
  logic               done;

  logic [63:0] add_a;
  logic [63:0] add_b;
  logic        add_sub;
  logic [64:0] add_res;
  logic        add_ge;
  logic [42:0] root_shift;
  logic [41:0] root_trial;
  logic [16:0] div_shift;
  logic [39:0] q_step;

  // Operand selection for the shared adder.
  always_comb begin
    root_shift = {rem[40:0], acc[63:62]};
    root_trial = {q, 2'b01};
    div_shift  = {rem[15:0], q[39]};
    case (state)
      MUL_ADD: begin
        add_a = acc; add_b = mcand; add_sub = 1'b0;
      end
      MUL_SUB: begin
        add_a = acc; add_b = mcand; add_sub = 1'b1;
      end
      ROOT: begin
        add_a = {21'd0, root_shift}; add_b = {22'd0, root_trial}; add_sub = 1'b1;
      end
      DIV_STD, DIV_MEAN: begin
        add_a = {47'd0, div_shift}; add_b = {48'd0, count}; add_sub = 1'b1;
      end
      default: begin
        add_a = 64'd0; add_b = 64'd0; add_sub = 1'b0;
      end
    endcase
  end

  // The shared adder; on a subtract the carry out means a >= b.
  always_comb begin
    add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {64'd0, add_sub};
    add_ge  = add_res[64];
    q_step  = {q[38:0], add_ge};
  end

  // Sequencer: shift-add products, digit-by-digit root, restoring divides.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      cnt  <= cnt - 6'd1;
      case (state)
        IDLE: begin
          if (req.start) begin
            acc     <= 64'd0;
            mcand   <= {17'd0, req.sum_squares};
            mplier  <= {16'd0, req.count};
            count   <= req.count;
            abs_sum <= req.sum[31] ? (~req.sum + 32'd1) : req.sum;
            neg     <= req.sum[31];
            cnt     <= MUL_ADD_STEPS;
            state   <= MUL_ADD;
          end
        end
        // Accumulate count * sum of squares.
        MUL_ADD: begin
          if (mplier[0]) acc <= add_res[63:0];
          if (cnt == 6'd1) begin
            mcand  <= {32'd0, abs_sum};
            mplier <= abs_sum;
            cnt    <= MUL_SUB_STEPS;
            state  <= MUL_SUB;
          end else begin
            mcand  <= {mcand[62:0], 1'b0};
            mplier <= {1'b0, mplier[31:1]};
          end
        end
        // Take the square of the sum away, leaving the scaled variance.
        MUL_SUB: begin
          if (mplier[0]) acc <= add_res[63:0];
          mcand  <= {mcand[62:0], 1'b0};
          mplier <= {1'b0, mplier[31:1]};
          if (cnt == 6'd1) begin
            rem   <= 43'd0;
            q     <= 40'd0;
            cnt   <= ROOT_STEPS;
            state <= ROOT;
          end
        end
        // Square root of the variance shifted up by 16 bits, two bits a step.
        ROOT: begin
          acc <= {acc[61:0], 2'b00};
          q   <= q_step;
          rem <= add_ge ? add_res[42:0] : root_shift;
          if (cnt == 6'd1) begin
            rem   <= 43'd0;
            cnt   <= DIV_STEPS;
            state <= DIV_STD;
          end
        end
        // Root divided by the count gives the standard deviation.
        DIV_STD: begin
          q   <= q_step;
          rem <= add_ge ? {27'd0, add_res[15:0]} : {27'd0, div_shift[15:0]};
          if (cnt == 6'd1) begin
            stdv  <= (count == '0) ? '0 : q_step[RES_W-1:0];
            q     <= {abs_sum, 8'd0};
            rem   <= 43'd0;
            cnt   <= DIV_STEPS;
            state <= DIV_MEAN;
          end
        end
        // Scaled magnitude of the sum divided by the count, sign restored.
        DIV_MEAN: begin
          q   <= q_step;
          rem <= add_ge ? {27'd0, add_res[15:0]} : {27'd0, div_shift[15:0]};
          if (cnt == 6'd1) begin
            if (count == '0) begin
              mean <= '0;
            end else if (neg) begin
              mean <= ~q_step[RES_W-1:0] + 24'd1;
            end else begin
              mean <= q_step[RES_W-1:0];
            end
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.mean_q8 = mean;
  assign rsp.std_q8  = stdv;

endmodule

@@ sv/summary_statistics_top.sv @@
// Summary statistics over sets of signed samples: running min, max, count,
// sum and sum of squares, then mean and population standard deviation.
// Depends on sst_pkg and sst_math.
//
// Samples enter one per item, and a set streams in at one sample per clock.
// The sample with the last mark starts the final computation, which runs
// on a single shared 64-bit adder under a sequencer: 16 steps for count
// times sum of squares, 32 for the square of the sum, 40 for the square
// root and 40 each for the two divides by the count. The START state
// starts the math unit, and input is stalled from the last sample until
// the result item is published. The result waits in an output register,
// so the next set may start streaming while it is not yet taken. Samples
// past 65535 in a set are dropped and reported through the overflow field.
module summary_statistics_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sst_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sst_pkg::SAMPLE_W-1:0]  minimum,
  output logic signed [sst_pkg::SAMPLE_W-1:0]  maximum,
  output logic        [sst_pkg::COUNT_W-1:0]   sample_count,
  output logic signed [sst_pkg::RES_W-1:0]     mean_q8,
  output logic        [sst_pkg::RES_W-1:0]     std_q8,
  output logic                                 overflow
);
  import sst_pkg::*;

  typedef enum logic [1:0] {COLLECT, START, CALC, HOLD} state_t;

  state_t                      state;
  logic signed [SAMPLE_W-1:0]  run_min;
  logic signed [SAMPLE_W-1:0]  run_max;
  logic        [SUM_W-1:0]     run_sum;
  logic        [SQ_W-1:0]      run_sum_squares;
  logic        [COUNT_W-1:0]   run_count;
  logic                        dropped_flag;

  logic signed [2*SAMPLE_W-1:0] square;
  logic                         slot_free;
  logic                         take;
  logic                         publish;
  sst_req_t                     req;
  sst_rsp_t                     rsp;

  // Square of the incoming sample and the output slot status.
  always_comb begin
    square    = sample * sample;
    slot_free = !out_valid || !out_stall;
    take      = in_valid && !in_stall;
    publish   = (state == HOLD || (state == CALC && rsp.done)) && slot_free;
  end

  assign in_stall = (state != COLLECT);

  // Totals handed to the math unit.
  always_comb begin
    req.start       = (state == START);
    req.count       = run_count;
    req.sum         = run_sum;
    req.sum_squares = run_sum_squares;
  end

  sst_math u_math (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Control, running totals and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= COLLECT;
      out_valid       <= 1'b0;
      run_min         <= SAMPLE_MAX;
      run_max         <= SAMPLE_MIN;
      run_sum         <= '0;
      run_sum_squares <= '0;
      run_count       <= '0;
      dropped_flag    <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        COLLECT: begin
          if (take) begin
            if (run_count == MAX_COUNT) begin
              dropped_flag <= 1'b1;
            end else begin
              if (sample < run_min) run_min <= sample;
              if (sample > run_max) run_max <= sample;
              run_sum         <= run_sum + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
              run_sum_squares <= run_sum_squares + {{(SQ_W-2*SAMPLE_W){1'b0}}, square};
              run_count       <= run_count + 16'd1;
            end
            if (last) state <= START;
          end
        end
        START: begin
          state <= CALC;
        end
        CALC, HOLD: begin
          if (publish) begin
            // Publish the result item and open a fresh set.
            minimum         <= run_min;
            maximum         <= run_max;
            sample_count    <= run_count;
            mean_q8         <= rsp.mean_q8;
            std_q8          <= rsp.std_q8;
            overflow        <= dropped_flag;
            run_min         <= SAMPLE_MAX;
            run_max         <= SAMPLE_MIN;
            run_sum         <= '0;
            run_sum_squares <= '0;
            run_count       <= '0;
            dropped_flag    <= 1'b0;
            state           <= COLLECT;
          end else if (rsp.done) begin
            state <= HOLD;
          end
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for summary_statistics_top: streams signed sample sets
// through the block and checks min, max, count, mean and standard deviation.
// Depends on sst_pkg and the summary_statistics_top RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sst_pkg::*;

  // One sample as it waits to be driven, with the idle cycles that precede it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       lst;
    int unsigned                gap;
  } sample_item_t;

  // Statistics of one completed set, as the block reports them.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic [COUNT_W-1:0]         n;
    logic signed [RES_W-1:0]    mean;
    logic [RES_W-1:0]           sd;
    logic                       ovf;
  } set_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic [COUNT_W-1:0] sample_count;
  logic signed [RES_W-1:0] mean_q8;
  logic [RES_W-1:0] std_q8;
  logic overflow;

  sample_item_t sample_queue[$];
  set_stats_t   stats_due[$];

  // Running totals of the set now streaming in.
  logic signed [SAMPLE_W-1:0] run_lo;
  logic signed [SAMPLE_W-1:0] run_hi;
  longint                     run_total;
  longint unsigned            run_energy;
  int unsigned                run_n;
  bit                         run_dropped;

  int unsigned items_total = 0;
  int unsigned items_accepted = 0;
  int unsigned sets_sent = 0;
  int unsigned sets_checked = 0;
  int unsigned sets_dropped = 0;
  int unsigned longest_set = 0;
  int unsigned mismatches = 0;
  int unsigned in_calm = 0;
  int unsigned gap_done = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;

  summary_statistics_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .minimum      (minimum),
    .maximum      (maximum),
    .sample_count (sample_count),
    .mean_q8      (mean_q8),
    .std_q8       (std_q8),
    .overflow     (overflow)
  );

  always #10 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bitwise integer square root of a wide value, floor.
  function automatic logic [63:0] int_sqrt(input logic [127:0] t);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= t) r = c;
    end
    return r;
  endfunction

  task automatic clear_running();
    run_lo      = SAMPLE_MAX;
    run_hi      = SAMPLE_MIN;
    run_total   = 0;
    run_energy  = 0;
    run_n       = 0;
    run_dropped = 0;
  endtask

  // Fold one accepted sample into the running totals; a last sample closes the
  // set and queues the statistics the block must report for it.
  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst);
    set_stats_t      want;
    longint unsigned mag;
    logic [127:0]    spread;
    logic [63:0]     root;
    longint          avg;
    if (run_n >= MAX_COUNT) begin
      run_dropped = 1'b1;
    end else begin
      if (s < run_lo) run_lo = s;
      if (s > run_hi) run_hi = s;
      run_total  = run_total + longint'(s);
      run_energy = run_energy + longint'(longint'(s) * longint'(s));
      run_n      = run_n + 1;
    end
    if (lst) begin
      avg  = 0;
      root = '0;
      if (run_n != 0) begin
        mag    = (run_total < 0) ? -run_total : run_total;
        spread = {64'd0, 64'(run_n)} * {64'd0, run_energy} - {64'd0, mag} * {64'd0, mag};
        root   = int_sqrt(spread << 16) / 64'(run_n);
        avg    = (run_total * 256) / longint'(run_n);
      end
      want.lo   = run_lo;
      want.hi   = run_hi;
      want.n    = COUNT_W'(run_n);
      want.mean = RES_W'(avg);
      want.sd   = RES_W'(root);
      want.ovf  = run_dropped;
      stats_due.insert(stats_due.size(), want);
      clear_running();
    end
  endtask

  // Queue one sample; dense samples almost never get an idle gap before them.
  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] v, input logic lst,
                              input bit dense);
    sample_item_t it;
    it.value = v;
    it.lst   = lst;
    if (dense) begin
      it.gap = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 3) : 0;
    end else if (in_calm > 0) begin
      in_calm = in_calm - 1;
      it.gap  = 0;
    end else if ($urandom_range(0, 99) < 2) begin
      in_calm = $urandom_range(50, 300);
      it.gap  = 0;
    end else begin
      it.gap = pick_idle();
    end
    sample_queue.insert(sample_queue.size(), it);
    items_total = items_total + 1;
    if (lst) sets_sent = sets_sent + 1;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // A long set of mostly extreme values, streamed back to back.
  task automatic queue_long_set(input int unsigned len);
    logic signed [SAMPLE_W-1:0] v;
    for (int unsigned i = 1; i <= len; i++) begin
      v = $urandom_range(0, 3) == 0 ? random_sample()
        : ($urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN);
      queue_sample(v, i == len, 1'b1);
    end
  endtask

  // Sample driver: offers the queued items, holding each until it is taken.
  always @(posedge clk) begin : drive_samples
    sample_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      clear_running();
      gap_done = 0;
    end else begin
      if (in_valid && !in_stall) begin
        accumulate_sample(sample, last);
        items_accepted = items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (gap_done < sample_queue[0].gap) begin
          gap_done = gap_done + 1;
          in_valid <= 1'b0;
        end else begin
          it = sample_queue.pop_front();
          gap_done = 0;
          in_valid <= 1'b1;
          sample   <= it.value;
          last     <= it.lst;
        end
      end
    end
  end

  // Result monitor: checks each taken result and throttles the output side.
  always @(posedge clk) begin : watch_results
    set_stats_t got;
    set_stats_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.lo   = minimum;
        got.hi   = maximum;
        got.n    = sample_count;
        got.mean = mean_q8;
        got.sd   = std_q8;
        got.ovf  = overflow;
        if (stats_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: result item with nothing expected: min %0d max %0d n %0d",
                     $realtime, got.lo, got.hi, got.n);
        end else begin
          want = stats_due.pop_front();
          sets_checked = sets_checked + 1;
          if (got.ovf) sets_dropped = sets_dropped + 1;
          if (got.n > longest_set) longest_set = got.n;
          if (got != want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: mismatch on set %0d", $realtime, sets_checked);
              $display("  expected min %0d max %0d n %0d mean %0d std %0d ovf %0b",
                       want.lo, want.hi, want.n, want.mean, want.sd, want.ovf);
              $display("  actual   min %0d max %0d n %0d mean %0d std %0d ovf %0b",
                       got.lo, got.hi, got.n, got.mean, got.sd, got.ovf);
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else if (out_calm > 0) begin
        out_stall <= 1'b0;
        out_calm = out_calm - 1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < 2) out_calm = $urandom_range(100, 400);
        else stall_left = pick_idle();
      end
    end
  end

  // Stimulus, end of run and verdict.
  initial begin : run_sets
    int unsigned len;
    int unsigned random_items;

    // Single-sample sets at the extremes and at zero.
    queue_sample(SAMPLE_MIN, 1'b1, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1, 1'b0);
    queue_sample(16'sd0, 1'b1, 1'b0);
    // Widest spread: both extremes in one set.
    queue_sample(SAMPLE_MIN, 1'b0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1, 1'b0);
    // Mean with a fraction, negative and positive, truncated toward zero.
    queue_sample(-16'sd1, 1'b0, 1'b0);
    queue_sample(16'sd0, 1'b0, 1'b0);
    queue_sample(16'sd0, 1'b1, 1'b0);
    queue_sample(16'sd1, 1'b0, 1'b0);
    queue_sample(16'sd0, 1'b0, 1'b0);
    queue_sample(16'sd0, 1'b1, 1'b0);
    // Constant sets at the extremes leave the min or max at its reset value.
    repeat (3) queue_sample(SAMPLE_MAX, 1'b0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1, 1'b0);
    queue_sample(16'sd5, 1'b0, 1'b0);
    queue_sample(-16'sd7, 1'b0, 1'b0);
    queue_sample(16'sd100, 1'b0, 1'b0);
    queue_sample(-16'sd3, 1'b1, 1'b0);

    // A long dense set of mostly extreme values, for large sums and spreads.
    queue_long_set(300);

    // Random sets, mostly short with a few long ones.
    random_items = 0;
    while (random_items < 1600) begin
      case ($urandom_range(0, 19))
        0, 1: len = 1;
        2: len = $urandom_range(100, 400);
        3, 4, 5: len = $urandom_range(17, 64);
        default: len = $urandom_range(2, 16);
      endcase
      for (int unsigned i = 1; i <= len; i++) queue_sample(random_sample(), i == len, 1'b0);
      random_items = random_items + len;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted != items_total) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);

    $display("Sent %0d samples in %0d sets; checked %0d result items.",
             items_total, sets_sent, sets_checked);
    $display("Sets with dropped samples: %0d; largest count seen: %0d; mismatches: %0d.",
             sets_dropped, longest_set, mismatches);
    if (stats_due.size() != 0)
      $display("%0d result items never arrived.", stats_due.size());
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #100ms;
    $display("Timeout: %0d of %0d samples taken, %0d results pending.",
             items_accepted, items_total, stats_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
